>>> sv/motor_feedback_frame_parser_unit_macros.svh
// ----------------------------------------------------------------------------
// Motor feedback frame parser assertion macros
// Shared concurrent assertion shorthands, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef MOTOR_FEEDBACK_FRAME_PARSER_UNIT_MACROS_SVH
`define MOTOR_FEEDBACK_FRAME_PARSER_UNIT_MACROS_SVH

// Condition in this cycle requires the consequence in the same cycle.
`define MFFP_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("mffp: same-cycle check failed");

// Condition in this cycle requires the consequence in the next cycle.
`define MFFP_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("mffp: next-cycle check failed");

`endif

>>> sv/mffp_pkg.sv
// ----------------------------------------------------------------------------
// Motor feedback frame parser package
// Register indexes, parse phases and the configuration bundle.
// ----------------------------------------------------------------------------
package mffp_pkg;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned PayloadW  = 32;
  localparam int unsigned CountW    = 3;

  localparam logic [CountW-1:0] DataBytes = 3'd4;

  localparam logic [CfgIndexW-1:0] CFG_HEADER_BYTE = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_TAIL_BYTE   = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_FIRST_ADDR  = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_SECOND_ADDR = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_MAX_TYPE    = 3'd4;

  localparam logic [ByteW-1:0] HeaderReset     = 8'd122;
  localparam logic [ByteW-1:0] TailReset       = 8'd123;
  localparam logic [ByteW-1:0] FirstAddrReset  = 8'd1;
  localparam logic [ByteW-1:0] SecondAddrReset = 8'd2;
  localparam logic [ByteW-1:0] MaxTypeReset    = 8'd4;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_ADDR  = 3'd1,
    PH_TYPE  = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHECK = 3'd4,
    PH_TAIL  = 3'd5
  } phase_t;

  typedef struct packed {
    logic [ByteW-1:0] header_byte;
    logic [ByteW-1:0] tail_byte;
    logic [ByteW-1:0] first_motor_addr;
    logic [ByteW-1:0] second_motor_addr;
    logic [ByteW-1:0] max_feedback_type;
  } cfg_t;

endpackage

>>> sv/mffp_cfg_regs.sv
// ----------------------------------------------------------------------------
// Motor feedback frame parser configuration registers
// Decodes the write port into the five frame-matching registers.
// ----------------------------------------------------------------------------
module mffp_cfg_regs
  import mffp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [ByteW-1:0]     cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_byte       <= HeaderReset;
      cfg.tail_byte         <= TailReset;
      cfg.first_motor_addr  <= FirstAddrReset;
      cfg.second_motor_addr <= SecondAddrReset;
      cfg.max_feedback_type <= MaxTypeReset;
    end else if (cfg_we) begin
      // Writes to indexes beyond the register list are dropped.
      unique case (cfg_index)
        CFG_HEADER_BYTE: cfg.header_byte       <= cfg_data;
        CFG_TAIL_BYTE:   cfg.tail_byte         <= cfg_data;
        CFG_FIRST_ADDR:  cfg.first_motor_addr  <= cfg_data;
        CFG_SECOND_ADDR: cfg.second_motor_addr <= cfg_data;
        CFG_MAX_TYPE:    cfg.max_feedback_type <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> sv/motor_feedback_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// Motor feedback frame parser: one received byte per cycle while rx_ready is high.
// A result appears in the output register the cycle after the tail byte.
// A byte is taken every cycle; only a tail byte waits while an older result
// is still held with res_ready low.
// Reset returns to header hunting with default registers and no result.
// ----------------------------------------------------------------------------
`include "motor_feedback_frame_parser_unit_macros.svh"

module motor_feedback_frame_parser_unit
  import mffp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [ByteW-1:0]     cfg_data,
  input  logic                 rx_valid,
  output logic                 rx_ready,
  input  logic [ByteW-1:0]     rx_byte,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic                 motor_index,
  output logic [ByteW-1:0]     feedback_type,
  output logic [PayloadW-1:0]  payload
);

  cfg_t cfg;

  mffp_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  phase_t              phase;
  phase_t              phase_next;
  logic [CountW-1:0]   data_count;
  logic [CountW-1:0]   data_count_next;
  logic [ByteW-1:0]    running_xor;
  logic [ByteW-1:0]    running_xor_next;
  logic                held_addr_index;
  logic                held_addr_index_next;
  logic [ByteW-1:0]    held_type;
  logic [ByteW-1:0]    held_type_next;
  logic [PayloadW-1:0] payload_shift;
  logic [PayloadW-1:0] payload_shift_next;
  logic [ByteW-1:0]    held_check;
  logic [ByteW-1:0]    held_check_next;
  logic                res_load;

  logic              rx_fire;
  logic              hit_first;
  logic              hit_second;
  logic              type_ok;
  logic [CountW-1:0] count_inc;

  // Only the tail byte can load the result register, so only that byte has to
  // wait for a held result to be taken.
  assign rx_ready   = !(res_valid && !res_ready && phase == PH_TAIL);
  assign rx_fire    = rx_valid && rx_ready;
  assign hit_first  = (rx_byte == cfg.first_motor_addr);
  assign hit_second = (rx_byte == cfg.second_motor_addr);
  assign type_ok    = (rx_byte <= cfg.max_feedback_type);
  assign count_inc  = data_count + 3'd1;

  // Next parse phase.
  always_comb begin
    phase_next = phase;
    if (rx_fire) begin
      unique case (phase)
        PH_HUNT:  if (rx_byte == cfg.header_byte) phase_next = PH_ADDR;
        PH_ADDR:  phase_next = (hit_first || hit_second) ? PH_TYPE : PH_HUNT;
        PH_TYPE:  phase_next = type_ok ? PH_DATA : PH_HUNT;
        PH_DATA:  if (count_inc >= DataBytes) phase_next = PH_CHECK;
        PH_CHECK: phase_next = PH_TAIL;
        PH_TAIL:  phase_next = PH_HUNT;
        default:  phase_next = PH_HUNT;
      endcase
    end
  end

  // Frame datapath updates and result load for the accepted byte.
  always_comb begin
    data_count_next      = data_count;
    running_xor_next     = running_xor;
    held_addr_index_next = held_addr_index;
    held_type_next       = held_type;
    payload_shift_next   = payload_shift;
    held_check_next      = held_check;
    res_load             = 1'b0;
    if (rx_fire) begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == cfg.header_byte) begin
            running_xor_next   = rx_byte;
            data_count_next    = '0;
            payload_shift_next = '0;
          end
        end
        PH_ADDR: begin
          if (hit_first || hit_second) begin
            // The first address wins when both registers hold the same value.
            held_addr_index_next = !hit_first;
            running_xor_next     = running_xor ^ rx_byte;
          end else begin
            data_count_next = '0;
          end
        end
        PH_TYPE: begin
          if (type_ok) begin
            held_type_next   = rx_byte;
            running_xor_next = running_xor ^ rx_byte;
          end else begin
            data_count_next = '0;
          end
        end
        PH_DATA: begin
          payload_shift_next = {payload_shift[PayloadW-ByteW-1:0], rx_byte};
          running_xor_next   = running_xor ^ rx_byte;
          data_count_next    = count_inc;
        end
        PH_CHECK: begin
          held_check_next = rx_byte;
        end
        PH_TAIL: begin
          res_load        = (rx_byte == cfg.tail_byte) && (running_xor == held_check);
          data_count_next = '0;
        end
        default: begin
          data_count_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      data_count      <= '0;
      running_xor     <= '0;
      held_addr_index <= 1'b0;
      held_type       <= '0;
      payload_shift   <= '0;
      held_check      <= '0;
    end else begin
      phase           <= phase_next;
      data_count      <= data_count_next;
      running_xor     <= running_xor_next;
      held_addr_index <= held_addr_index_next;
      held_type       <= held_type_next;
      payload_shift   <= payload_shift_next;
      held_check      <= held_check_next;
    end
  end

  // Result register: loaded on a good tail, cleared once the result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      motor_index   <= held_addr_index;
      feedback_type <= held_type;
      payload       <= payload_shift;
    end
  end

  `MFFP_ASSERT_NEXT(a_tail_returns_hunt, rx_fire && phase == PH_TAIL, phase == PH_HUNT)
  `MFFP_ASSERT_NEXT(a_fourth_data_to_check,
                    rx_fire && phase == PH_DATA && data_count == 3'd3, phase == PH_CHECK)
  `MFFP_ASSERT_NOW(a_data_count_bound, phase == PH_DATA, data_count < DataBytes)
  `MFFP_ASSERT_NOW(a_hunt_count_clear, phase == PH_HUNT, data_count == 3'd0)

endmodule
